// File: hdl/sesi_pkg.sv
package sesi_pkg;

    localparam int SET_CAPACITY = 64;
    localparam int CNT_W = $clog2(SET_CAPACITY + 1);
    localparam int IDX_W = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;

    localparam int ADDR_W = 32;
    localparam int PORT_W = 16;
    localparam int STATUS_W = 3;
    localparam int OUT_CNT_W = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [7:0] FIRST_OCTET_LIMIT = 8'd224;

    // address in the upper bits so a packed compare orders by address, then port
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
    } endpoint_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED   = 3'd0,
        ST_PRESENT = 3'd1,
        ST_FULL    = 3'd2,
        ST_INVALID = 3'd3,
        ST_SELF    = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXCLUDE_SELF = 2'd0,
        CFG_SELF_ADDRESS = 2'd1,
        CFG_SELF_PORT    = 2'd2
    } cfg_index_t;

endpackage

// File: hdl/sorted_endpoint_set_insert_unit.sv
// sorted endpoint set insert unit: one request in, one result out
// throughput: one request at a time, ready again the cycle after the result is loaded;
// search and shift walk the store one entry a cycle, a blocked result register adds its stall
// reset: aresetn synchronous active low, clears control and config regs; entries need no clearing
module sorted_endpoint_set_insert_unit
    import sesi_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [ADDR_W-1:0]    s_endpoint_address,
    input  logic [PORT_W-1:0]    s_endpoint_port,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [STATUS_W-1:0]  m_status,
    output logic [OUT_CNT_W-1:0] m_slot,
    output logic [OUT_CNT_W-1:0] m_entry_total
);

    // sequencer states
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_CHECK  = 7'b0000010,
        ST_SEARCH = 7'b0000100,
        ST_DECIDE = 7'b0001000,
        ST_SHIFT  = 7'b0010000,
        ST_INSERT = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic              excl_en_reg;
    logic [ADDR_W-1:0] self_addr_reg;
    logic [PORT_W-1:0] self_port_reg;

    // request and working registers
    endpoint_t         key_reg, key_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  slot_reg, slot_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic              found_reg, found_next;
    status_t           status_reg, status_next;

    // output register
    logic                 m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]  m_status_reg, m_status_next;
    logic [OUT_CNT_W-1:0] m_slot_reg, m_slot_next;
    logic [OUT_CNT_W-1:0] m_total_reg, m_total_next;

    // entry store port
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    endpoint_t        mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    endpoint_t        mem_rdata;

    // compare unit: offered key against the entry just read
    logic key_eq;
    logic key_lt;

    logic [7:0]       first_octet;
    logic             bad_endpoint;
    logic             is_self;
    logic [CNT_W-1:0] idx_inc;
    logic             out_free;

    sesi_store u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign key_eq = (key_reg == mem_rdata);
    assign key_lt = (key_reg < mem_rdata);

    // validity and self check on the captured request
    assign first_octet  = key_reg.addr[ADDR_W-1 -: 8];
    assign bad_endpoint = (key_reg.port == '0) || (first_octet == 8'd0)
                          || (first_octet >= FIRST_OCTET_LIMIT);
    assign is_self      = excl_en_reg && (key_reg.addr == self_addr_reg)
                          && (key_reg.port == self_port_reg);

    assign idx_inc  = ptr_reg + 1'b1;
    assign out_free = !m_valid_reg || m_ready;

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_slot        = m_slot_reg;
    assign m_entry_total = m_total_reg;

    // configuration writes, index three is unused
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            excl_en_reg   <= 1'b0;
            self_addr_reg <= '0;
            self_port_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_EXCLUDE_SELF: excl_en_reg   <= cfg_data[0];
                CFG_SELF_ADDRESS: self_addr_reg <= cfg_data[ADDR_W-1:0];
                CFG_SELF_PORT:    self_port_reg <= cfg_data[PORT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        key_next      = key_reg;
        count_next    = count_reg;
        slot_next     = slot_reg;
        ptr_next      = ptr_reg;
        found_next    = found_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_slot_next   = m_slot_reg;
        m_total_next  = m_total_reg;
        mem_we        = 1'b0;
        mem_waddr     = ptr_reg[IDX_W-1:0];
        mem_wdata     = mem_rdata;
        mem_raddr     = '0;

        // result taken downstream
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    key_next.addr = s_endpoint_address;
                    key_next.port = s_endpoint_port;
                    state_next    = ST_CHECK;
                end
            end

            ST_CHECK: begin
                // read of entry zero goes out here for the search
                mem_raddr  = '0;
                slot_next  = '0;
                ptr_next   = '0;
                found_next = 1'b0;
                if (bad_endpoint) begin
                    status_next = ST_INVALID;
                    state_next  = ST_DONE;
                end else if (is_self) begin
                    status_next = ST_SELF;
                    state_next  = ST_DONE;
                end else if (count_reg == '0) begin
                    state_next = ST_DECIDE;
                end else begin
                    state_next = ST_SEARCH;
                end
            end

            ST_SEARCH: begin
                // ptr holds the entry whose data is on the read port
                mem_raddr = idx_inc[IDX_W-1:0];
                if (key_eq) begin
                    found_next = 1'b1;
                    slot_next  = ptr_reg;
                    state_next = ST_DECIDE;
                end else if (key_lt) begin
                    slot_next  = ptr_reg;
                    state_next = ST_DECIDE;
                end else if (idx_inc == count_reg) begin
                    slot_next  = count_reg;
                    state_next = ST_DECIDE;
                end else begin
                    ptr_next = idx_inc;
                end
            end

            ST_DECIDE: begin
                // prefetch the top entry in case a shift follows
                mem_raddr = IDX_W'(count_reg - 1'b1);
                ptr_next  = count_reg;
                if (found_reg) begin
                    status_next = ST_PRESENT;
                    state_next  = ST_DONE;
                end else if (count_reg == CNT_W'(SET_CAPACITY)) begin
                    status_next = ST_FULL;
                    state_next  = ST_DONE;
                end else if (slot_reg == count_reg) begin
                    state_next = ST_INSERT;
                end else begin
                    state_next = ST_SHIFT;
                end
            end

            ST_SHIFT: begin
                // move entry ptr-1 up to ptr, fetch ptr-2 for the next step
                mem_we    = 1'b1;
                mem_waddr = ptr_reg[IDX_W-1:0];
                mem_wdata = mem_rdata;
                mem_raddr = IDX_W'(ptr_reg - 2'd2);
                ptr_next  = ptr_reg - 1'b1;
                if (ptr_next == slot_reg) begin
                    state_next = ST_INSERT;
                end
            end

            ST_INSERT: begin
                mem_we      = 1'b1;
                mem_waddr   = slot_reg[IDX_W-1:0];
                mem_wdata   = key_reg;
                count_next  = count_reg + 1'b1;
                status_next = ST_ADDED;
                state_next  = ST_DONE;
            end

            ST_DONE: begin
                // hand the result over once the output register is free
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_slot_next   = OUT_CNT_W'(slot_reg);
                    m_total_next  = OUT_CNT_W'(count_reg);
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // working and result payload
    always_ff @(posedge aclk) begin
        key_reg      <= key_next;
        slot_reg     <= slot_next;
        ptr_reg      <= ptr_next;
        found_reg    <= found_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
        m_slot_reg   <= m_slot_next;
        m_total_reg  <= m_total_next;
    end

`ifndef SYNTH
    // fill count stays within the set
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(SET_CAPACITY))
        else $error("fill count above capacity");

    // fill count only ever grows by one, and only through an insert
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (count_reg != $past(count_reg)))
        |-> ((count_reg == CNT_W'($past(count_reg) + 1'b1))
             && ($past(state_reg) == ST_INSERT)))
        else $error("fill count changed outside an insert");

    // a shift never moves entries below the insertion slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT) |-> (ptr_reg > slot_reg))
        else $error("shift pointer at or below slot");

    // an added result reports the grown count and a slot inside it
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_valid_reg) && (m_status_reg == ST_ADDED))
        |-> ((m_total_reg == OUT_CNT_W'(count_reg)) && (m_slot_reg < m_total_reg)))
        else $error("added result inconsistent with fill count");
`endif

endmodule

// File: hdl/sesi_store.sv
module sesi_store
    import sesi_pkg::*;
(
    input  logic      aclk,
    input  logic      wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  endpoint_t wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output endpoint_t rd_data
);

    // sorted entries, one write and one registered read per cycle
    endpoint_t mem [SET_CAPACITY];
    endpoint_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
